// ===== hdl/mtx_pkg.sv =====
// ============================================================================
// mtx_pkg
// Shared types and constants for the mutex table with FIFO wait queues.
// ============================================================================
package mtx_pkg;

    localparam int MUTEX_SLOTS = 16;
    localparam int TASK_COUNT  = 16;
    localparam int SLOT_AW     = $clog2(MUTEX_SLOTS);
    localparam int TASK_AW     = $clog2(TASK_COUNT);

    // field widths of the request and result ports
    localparam int OP_W     = 3;
    localparam int TASK_W   = 4;
    localparam int MUTEX_W  = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_LOCK    = 3'd2,
        OP_TRYLOCK = 3'd3,
        OP_UNLOCK  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_NOT_CREATOR = 3'd2,
        ST_LOCKED      = 3'd3,
        ST_WAITERS     = 3'd4,
        ST_NOT_OWNER   = 3'd5,
        ST_FULL        = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    // one entry of the slot memory
    typedef struct packed {
        logic              locked;
        logic [TASK_W-1:0] owner;
        logic [TASK_W-1:0] creator;
        logic              nonempty;
        logic [TASK_W-1:0] head;
        logic [TASK_W-1:0] tail;
    } t_slot_entry;

    localparam int SLOT_ENTRY_W = $bits(t_slot_entry);

endpackage

// ===== hdl/mtx_ram.sv =====
// ============================================================================
// mtx_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module mtx_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mtx_find_free.sv =====
// ============================================================================
// mtx_find_free
// Priority encoder that picks the lowest slot whose valid mark is clear.
// ============================================================================
module mtx_find_free (
    input  logic [mtx_pkg::MUTEX_SLOTS-1:0] i_valid,
    output logic                            o_found,
    output logic [mtx_pkg::SLOT_AW-1:0]     o_idx
);
    import mtx_pkg::*;

    // scan from the top so the lowest free slot wins
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = MUTEX_SLOTS - 1; i >= 0; i--) begin
            if (!i_valid[i]) begin
                o_found = 1'b1;
                o_idx   = SLOT_AW'(i);
            end
        end
    end

endmodule

// ===== hdl/mutex_table_with_wait_queues.sv =====
// ============================================================================
// mutex_table_with_wait_queues
// Mutex slot table with per-slot FIFO wait queues kept as linked lists.
// ============================================================================
// A request is taken when start is high and busy is low. Most requests pass
// through two steps from acceptance to the next possible acceptance: reading
// the slot memory, then deciding and writing back. An unlock that hands the
// mutex to a waiter while more than one task is queued adds a third step,
// taking the next waiter from the task link memory. The result appears on
// the o_ result ports for exactly one cycle with o_done high, in the cycle
// after the write-back; it is not held, so the receiver must take it then.
// Valid marks live in flip-flops and clear at reset, so the block is ready
// right after reset with no clearing pass.
module mutex_table_with_wait_queues (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mtx_pkg::OP_W-1:0]     i_op,
    input  logic [mtx_pkg::TASK_W-1:0]   i_task_id,
    input  logic [mtx_pkg::MUTEX_W-1:0]  i_mutex_id,
    output logic                         o_done,
    output logic [mtx_pkg::STATUS_W-1:0] o_status,
    output logic [mtx_pkg::MUTEX_W-1:0]  o_slot_out,
    output logic                         o_blocked,
    output logic                         o_woken_valid,
    output logic [mtx_pkg::TASK_W-1:0]   o_woken_task
);
    import mtx_pkg::*;

    t_state r_state, n_state;

    // captured request
    logic [OP_W-1:0]    r_op;
    logic [TASK_W-1:0]  r_task;
    logic [MUTEX_W-1:0] r_mutex;

    logic [MUTEX_SLOTS-1:0] r_valid, n_valid;

    // result registers
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [MUTEX_W-1:0]  r_slot_out, n_slot_out;
    logic                r_blocked, n_blocked;
    logic                r_woken_valid, n_woken_valid;
    logic [TASK_W-1:0]   r_woken_task, n_woken_task;

    // memory ports
    logic                    slot_re, slot_we;
    logic [SLOT_AW-1:0]      slot_raddr, slot_waddr;
    logic [SLOT_ENTRY_W-1:0] slot_rdata_raw;
    t_slot_entry             slot_rd, slot_wd;
    logic                    link_re, link_we;
    logic [TASK_AW-1:0]      link_raddr, link_waddr;
    logic [TASK_W-1:0]       link_rdata, link_wd;

    logic               accept;
    logic               slot_ok, task_ok;
    logic               free_found;
    logic [SLOT_AW-1:0] free_idx;
    logic [SLOT_AW-1:0] cur_slot;
    logic               need_link;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign cur_slot = r_mutex[SLOT_AW-1:0];
    assign slot_rd  = t_slot_entry'(slot_rdata_raw);
    assign slot_ok  = (int'(r_mutex) < MUTEX_SLOTS) && r_valid[cur_slot];
    assign task_ok  = (int'(r_task) < TASK_COUNT);

    // slot memory: per-slot lock, owner, creator and queue pointers
    mtx_ram #(
        .DEPTH (MUTEX_SLOTS),
        .WIDTH (SLOT_ENTRY_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (SLOT_ENTRY_W'(slot_wd)),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata_raw)
    );

    // task link memory: next waiter behind each queued task
    mtx_ram #(
        .DEPTH (TASK_COUNT),
        .WIDTH (TASK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wd),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    mtx_find_free u_find_free (
        .i_valid (r_valid),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    // slot read issued with the accepted transaction
    assign slot_re    = accept;
    assign slot_raddr = i_mutex_id[SLOT_AW-1:0];

    // unlock with more than one waiter needs the link of the head task
    assign need_link = (r_state == S_EXEC) && (r_op == OP_UNLOCK) && task_ok && slot_ok
                       && slot_rd.locked && (slot_rd.owner == r_task)
                       && slot_rd.nonempty && (slot_rd.head != slot_rd.tail);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = need_link ? S_LINK : S_IDLE;
            end
            S_LINK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // decision, memory writes and result
    always_comb begin
        n_valid       = r_valid;
        n_done        = 1'b0;
        n_status      = r_status;
        n_slot_out    = r_slot_out;
        n_blocked     = r_blocked;
        n_woken_valid = r_woken_valid;
        n_woken_task  = r_woken_task;
        slot_we       = 1'b0;
        slot_waddr    = cur_slot;
        slot_wd       = slot_rd;
        link_re       = 1'b0;
        link_raddr    = slot_rd.head[TASK_AW-1:0];
        link_we       = 1'b0;
        link_waddr    = slot_rd.tail[TASK_AW-1:0];
        link_wd       = r_task;

        case (r_state)
            S_EXEC: begin
                n_done        = !need_link;
                n_status      = ST_OK;
                n_slot_out    = r_mutex;
                n_blocked     = 1'b0;
                n_woken_valid = 1'b0;
                n_woken_task  = '0;
                if (r_op > OP_UNLOCK) begin
                    n_status = ST_OK;
                end else if (!task_ok) begin
                    n_status = ST_INVALID;
                end else if (r_op == OP_ALLOC) begin
                    // take the lowest free slot
                    if (free_found) begin
                        n_valid[free_idx] = 1'b1;
                        slot_we           = 1'b1;
                        slot_waddr        = free_idx;
                        slot_wd           = '0;
                        slot_wd.creator   = r_task;
                        n_slot_out        = MUTEX_W'(free_idx);
                    end else begin
                        n_status   = ST_FULL;
                        n_slot_out = '0;
                    end
                end else if (!slot_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    case (t_op'(r_op))
                        OP_FREE: begin
                            if (slot_rd.creator != r_task) begin
                                n_status = ST_NOT_CREATOR;
                            end else if (slot_rd.locked) begin
                                n_status = ST_LOCKED;
                            end else if (slot_rd.nonempty) begin
                                n_status = ST_WAITERS;
                            end else begin
                                n_valid[cur_slot] = 1'b0;
                            end
                        end
                        OP_LOCK, OP_TRYLOCK: begin
                            if (!slot_rd.locked) begin
                                slot_we        = 1'b1;
                                slot_wd.locked = 1'b1;
                                slot_wd.owner  = r_task;
                            end else if (r_op == OP_LOCK) begin
                                // append to the wait queue
                                slot_we      = 1'b1;
                                slot_wd.tail = r_task;
                                n_blocked    = 1'b1;
                                if (slot_rd.nonempty) begin
                                    link_we = (int'(slot_rd.tail) < TASK_COUNT);
                                end else begin
                                    slot_wd.head     = r_task;
                                    slot_wd.nonempty = 1'b1;
                                end
                            end else begin
                                n_status = ST_LOCKED;
                            end
                        end
                        OP_UNLOCK: begin
                            if (!slot_rd.locked || (slot_rd.owner != r_task)) begin
                                n_status = ST_NOT_OWNER;
                            end else if (slot_rd.nonempty) begin
                                if (slot_rd.head == slot_rd.tail) begin
                                    // last waiter takes over, queue empties
                                    slot_we          = 1'b1;
                                    slot_wd.nonempty = 1'b0;
                                    slot_wd.owner    = slot_rd.head;
                                    n_woken_valid    = 1'b1;
                                    n_woken_task     = slot_rd.head;
                                end else begin
                                    link_re = 1'b1;
                                end
                            end else begin
                                slot_we        = 1'b1;
                                slot_wd.locked = 1'b0;
                                slot_wd.owner  = '0;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_LINK: begin
                // head moves to the next waiter, old head owns the mutex
                n_done        = 1'b1;
                slot_we       = 1'b1;
                slot_wd.owner = slot_rd.head;
                slot_wd.head  = link_rdata;
                n_woken_valid = 1'b1;
                n_woken_task  = slot_rd.head;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_done  <= n_done;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_task  <= i_task_id;
            r_mutex <= i_mutex_id;
        end
        r_status      <= n_status;
        r_slot_out    <= n_slot_out;
        r_blocked     <= n_blocked;
        r_woken_valid <= n_woken_valid;
        r_woken_task  <= n_woken_task;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_out    = r_slot_out;
    assign o_blocked     = r_blocked;
    assign o_woken_valid = r_woken_valid;
    assign o_woken_task  = r_woken_task;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the mutex table with FIFO wait queues. A short
// table of directed requests walks the error codes but ST_WAITERS, the hand-off
// on unlock, a task queued on two slots and a full table; then weighted random
// requests drive mostly well-formed lock/unlock traffic from live table state.
// Each result is checked against an in-bench model or its directed row's answer.
// ============================================================================
module tb;
    import mtx_pkg::*;

    // spare operation codes, answered with ok and no state change
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 610;
    localparam int IDLE_LIMIT      = 200;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        t_status            status;
        logic [MUTEX_W-1:0] slot;
        logic               blocked;
        logic               woken_valid;
        logic [TASK_W-1:0]  woken_task;
    } t_reply;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TASK_W-1:0]  tk;
        logic [MUTEX_W-1:0] mx;
        logic [5:0]         reps;
        logic               typed;
        t_status            status;
        logic [MUTEX_W-1:0] slot;
    } t_step;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_op;
    logic [TASK_W-1:0]   i_task_id;
    logic [MUTEX_W-1:0]  i_mutex_id;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [MUTEX_W-1:0]  o_slot_out;
    logic                o_blocked;
    logic                o_woken_valid;
    logic [TASK_W-1:0]   o_woken_task;

    // shadow copy of the mutex table
    bit                in_use      [MUTEX_SLOTS];
    bit                held        [MUTEX_SLOTS];
    bit [TASK_W-1:0]   holder      [MUTEX_SLOTS];
    bit [TASK_W-1:0]   maker       [MUTEX_SLOTS];
    bit                has_waiters [MUTEX_SLOTS];
    bit [TASK_W-1:0]   wait_first  [MUTEX_SLOTS];
    bit [TASK_W-1:0]   wait_last   [MUTEX_SLOTS];
    bit [TASK_W-1:0]   next_waiter [TASK_COUNT];
    bit                link_set    [TASK_COUNT];

    t_reply expected_replies[$];
    t_step  plan[$];
    int     n_errors;
    int     idle_cycles;
    bit     steady;

    mutex_table_with_wait_queues dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_task_id     (i_task_id),
        .i_mutex_id    (i_mutex_id),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_blocked     (o_blocked),
        .o_woken_valid (o_woken_valid),
        .o_woken_task  (o_woken_task)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one request to the shadow table and return its answer
    function automatic t_reply apply_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] tk,
                                             logic [MUTEX_W-1:0] mx);
        t_reply            r;
        logic [TASK_W-1:0] first;
        bit                slot_ok;
        r = '0;
        r.status = ST_OK;
        r.slot = mx;
        slot_ok = (mx < MUTEX_SLOTS) && in_use[mx];
        if (op > OP_UNLOCK) begin
            r.status = ST_OK;
        end else if (tk >= TASK_COUNT) begin
            r.status = ST_INVALID;
        end else if (op == OP_ALLOC) begin
            // lowest free slot wins
            r.status = ST_FULL;
            r.slot = '0;
            for (int i = 0; i < MUTEX_SLOTS; i++) begin
                if (!in_use[i] && r.status == ST_FULL) begin
                    in_use[i] = 1'b1;
                    held[i] = 1'b0;
                    holder[i] = '0;
                    maker[i] = tk;
                    has_waiters[i] = 1'b0;
                    r.status = ST_OK;
                    r.slot = MUTEX_W'(i);
                end
            end
        end else if (!slot_ok) begin
            r.status = ST_INVALID;
        end else if (op == OP_FREE) begin
            if (maker[mx] != tk)
                r.status = ST_NOT_CREATOR;
            else if (held[mx])
                r.status = ST_LOCKED;
            else if (has_waiters[mx])
                r.status = ST_WAITERS;
            else
                in_use[mx] = 1'b0;
        end else if (op == OP_LOCK || op == OP_TRYLOCK) begin
            if (!held[mx]) begin
                held[mx] = 1'b1;
                holder[mx] = tk;
            end else if (op == OP_LOCK) begin
                // append to the wait list
                if (has_waiters[mx]) begin
                    next_waiter[wait_last[mx]] = tk;
                    link_set[wait_last[mx]] = 1'b1;
                end else begin
                    wait_first[mx] = tk;
                    has_waiters[mx] = 1'b1;
                end
                wait_last[mx] = tk;
                r.blocked = 1'b1;
            end else begin
                r.status = ST_LOCKED;
            end
        end else begin
            // unlock: hand over to the oldest waiter or release
            if (!held[mx] || holder[mx] != tk) begin
                r.status = ST_NOT_OWNER;
            end else if (has_waiters[mx]) begin
                first = wait_first[mx];
                if (first == wait_last[mx])
                    has_waiters[mx] = 1'b0;
                else
                    wait_first[mx] = next_waiter[first];
                holder[mx] = first;
                r.woken_valid = 1'b1;
                r.woken_task = first;
            end else begin
                held[mx] = 1'b0;
                holder[mx] = '0;
            end
        end
        return r;
    endfunction

    function automatic void add_step(logic [OP_W-1:0] op, logic [TASK_W-1:0] tk,
                                     logic [MUTEX_W-1:0] mx, int reps, bit typed,
                                     t_status st, logic [MUTEX_W-1:0] sl);
        t_step s;
        s.op = op;
        s.tk = tk;
        s.mx = mx;
        s.reps = 6'(reps);
        s.typed = typed;
        s.status = st;
        s.slot = sl;
        plan.push_back(s);
    endfunction

    // wait out the sender gap, then hold the request until the block takes it
    task automatic issue(logic [OP_W-1:0] op, logic [TASK_W-1:0] tk, logic [MUTEX_W-1:0] mx,
                         bit typed, t_reply fixed);
        int     gap;
        t_reply guess;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            i_op <= OP_W'($urandom);
            i_task_id <= TASK_W'($urandom);
            i_mutex_id <= MUTEX_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_task_id <= tk;
        i_mutex_id <= mx;
        do @(posedge i_clk); while (busy);
        guess = apply_request(op, tk, mx);
        expected_replies.push_back(typed ? fixed : guess);
    endtask

    // weighted request drawn from the live table state
    task automatic pick_request(output logic [OP_W-1:0] op, output logic [TASK_W-1:0] tk,
                                output logic [MUTEX_W-1:0] mx);
        int                 roll;
        logic [MUTEX_W-1:0] taken[$];
        logic [MUTEX_W-1:0] open[$];
        logic [MUTEX_W-1:0] owned[$];
        roll = $urandom_range(0, 99);
        for (int i = 0; i < MUTEX_SLOTS; i++) begin
            if (in_use[i]) begin
                taken.push_back(MUTEX_W'(i));
                if (held[i])
                    owned.push_back(MUTEX_W'(i));
                else
                    open.push_back(MUTEX_W'(i));
            end
        end
        op = OP_W'($urandom_range(0, 7));
        tk = TASK_W'($urandom);
        mx = MUTEX_W'($urandom);
        if (roll < 8) begin
            op = OP_ALLOC;
        end else if (roll < 18) begin
            op = OP_FREE;
            if (open.size() > 0 && roll < 16) begin
                mx = open[$urandom_range(0, open.size() - 1)];
                tk = maker[mx];
            end
        end else if (roll < 58) begin
            op = (roll < 46) ? OP_LOCK : OP_TRYLOCK;
            if (taken.size() > 0 && roll % 10 != 0)
                mx = taken[$urandom_range(0, taken.size() - 1)];
        end else if (roll < 92) begin
            op = OP_UNLOCK;
            if (owned.size() > 0 && roll < 88) begin
                mx = owned[$urandom_range(0, owned.size() - 1)];
                tk = holder[mx];
            end
        end
        // a hand-off must not follow a waiter link that was never written
        if (op == OP_UNLOCK && in_use[mx] && held[mx] && holder[mx] == tk && has_waiters[mx]
            && wait_first[mx] != wait_last[mx] && !link_set[wait_first[mx]])
            op = OP_TRYLOCK;
    endtask

    // result checker: outputs sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_done) begin
            if (expected_replies.size() == 0) begin
                $error("result with nothing pending: status %0d slot %0d", o_status,
                       o_slot_out);
                n_errors++;
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_errors++;
                end
                if (o_slot_out !== want.slot) begin
                    $error("slot_out: expected %0d, got %0d", want.slot, o_slot_out);
                    n_errors++;
                end
                if (o_blocked !== want.blocked) begin
                    $error("blocked: expected %0d, got %0d", want.blocked, o_blocked);
                    n_errors++;
                end
                if (o_woken_valid !== want.woken_valid) begin
                    $error("woken_valid: expected %0d, got %0d", want.woken_valid,
                           o_woken_valid);
                    n_errors++;
                end
                if (o_woken_task !== want.woken_task) begin
                    $error("woken_task: expected %0d, got %0d", want.woken_task,
                           o_woken_task);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_reply             fixed;
        logic [OP_W-1:0]    op;
        logic [TASK_W-1:0]  tk;
        logic [MUTEX_W-1:0] mx;
        n_errors = 0;
        idle_cycles = 0;
        steady = 1'b0;
        start = 1'b0;
        i_op = '0;
        i_task_id = '0;
        i_mutex_id = '0;
        i_rst_n = 1'b0;

        // directed table: empty table, hand-off chain, requeue, fill up
        add_step(OP_FREE,     0,  15, 1, 1, ST_INVALID,     15);
        add_step(OP_UNLOCK,   15, 0,  1, 1, ST_INVALID,     0);
        add_step(OP_LOCK,     0,  0,  1, 1, ST_INVALID,     0);
        add_step(OP_TRYLOCK,  9,  3,  1, 1, ST_INVALID,     3);
        add_step(OP_SPARE_LO, 3,  9,  1, 1, ST_OK,          9);
        add_step(OP_SPARE_HI, 15, 15, 1, 1, ST_OK,          15);
        add_step(OP_ALLOC,    15, 15, 1, 1, ST_OK,          0);
        add_step(OP_ALLOC,    0,  7,  1, 1, ST_OK,          1);
        add_step(OP_LOCK,     3,  0,  1, 0, ST_OK,          0);
        add_step(OP_TRYLOCK,  4,  0,  1, 1, ST_LOCKED,      0);
        add_step(OP_LOCK,     5,  0,  1, 0, ST_OK,          0);
        // owner queues behind itself
        add_step(OP_LOCK,     3,  0,  1, 0, ST_OK,          0);
        add_step(OP_FREE,     15, 0,  1, 1, ST_LOCKED,      0);
        add_step(OP_FREE,     0,  0,  1, 1, ST_NOT_CREATOR, 0);
        add_step(OP_UNLOCK,   5,  0,  1, 1, ST_NOT_OWNER,   0);
        add_step(OP_TRYLOCK,  15, 1,  1, 0, ST_OK,          0);
        // a waiter queues again on another slot
        add_step(OP_LOCK,     5,  1,  1, 0, ST_OK,          0);
        add_step(OP_UNLOCK,   3,  0,  1, 0, ST_OK,          0);
        add_step(OP_UNLOCK,   5,  0,  1, 0, ST_OK,          0);
        add_step(OP_UNLOCK,   3,  0,  1, 0, ST_OK,          0);
        add_step(OP_UNLOCK,   15, 1,  1, 0, ST_OK,          0);
        add_step(OP_UNLOCK,   5,  1,  1, 0, ST_OK,          0);
        add_step(OP_FREE,     15, 0,  1, 1, ST_OK,          0);
        add_step(OP_ALLOC,    2,  0,  15, 0, ST_OK,         0);
        add_step(OP_ALLOC,    6,  9,  1, 1, ST_FULL,        0);
        add_step(OP_FREE,     0,  1,  1, 1, ST_OK,          1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            repeat (plan[n].reps) begin
                fixed = '0;
                fixed.status = plan[n].status;
                fixed.slot = plan[n].slot;
                issue(plan[n].op, plan[n].tk, plan[n].mx, plan[n].typed, fixed);
            end
        end

        // random traffic with occasional back-to-back bursts
        repeat (RANDOM_REQUESTS) begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            pick_request(op, tk, mx);
            issue(op, tk, mx, 1'b0, '0);
        end
        start <= 1'b0;

        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
